// ===== rtl/tmtw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tmtw_pkg;

  // default screen geometry
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W = 1;

  // request modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_BACK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ERR   = 8'h45;

  localparam logic [ATTR_W-1:0] ATTR_NONE = 8'h00;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 1'b1;
  localparam logic [ATTR_W-1:0]    DEFAULT_ATTR_RST = 8'd15;
  localparam logic [ATTR_W-1:0]    ERROR_ATTR_RST   = 8'd4;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAR_W-1:0] char_code;
    logic              use_cursor;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ATTR_W-1:0] attr;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              coord_error;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attr;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLR,
    ST_RDW,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic rd_cap;
    logic clr_wr;
    logic scr_rd;
    logic scr_wr;
    logic fill_wr;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       scroll_needed;
    logic       cnt_last;
    logic       cnt_copy_last;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/tmtw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/tmtw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmtw_ctrl
  import tmtw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_INIT: begin
        cmd.clr_wr = 1'b1;
        if (status.cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (status.mode)
          MODE_PUT:   state_nxt = status.scroll_needed ? ST_SCR_RD : ST_FIN;
          MODE_BACK:  state_nxt = ST_FIN;
          MODE_CLEAR: state_nxt = ST_CLR;
          MODE_READ:  state_nxt = ST_RDW;
          default:    state_nxt = ST_FIN;
        endcase
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.cnt_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_RDW: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_SCR_RD: begin
        cmd.scr_rd = 1'b1;
        state_nxt  = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.scr_wr = 1'b1;
        state_nxt  = status.cnt_copy_last ? ST_FILL : ST_SCR_RD;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        if (status.cnt_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tmtw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmtw_datapath
  import tmtw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ctrl_cmd_t              cmd,
  output dp_status_t                  status,
  input  wire in_item_t               in_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ATTR_W-1:0]      cfg_data,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output out_item_t                   out_item
);

  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELLS - COLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLS);

  in_item_t          item_r;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ATTR_W-1:0] def_attr_r, err_attr_r;
  logic [ADDR_W-1:0] cnt_r;
  logic              err_r;
  logic [CHAR_W-1:0] rd_char_r;
  logic [ATTR_W-1:0] rd_attr_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [COL_W-1:0]  tgt_col, addr_col;
  logic [ROW_W-1:0]  tgt_row, addr_row;
  logic [ATTR_W-1:0] attr_sel;
  logic              bad;
  logic [ADDR_W-1:0] cell_addr;
  logic              scroll_needed;
  logic              dec_we;
  logic [ADDR_W-1:0] dec_waddr;
  logic [CELL_W-1:0] dec_wdata;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // target cell and decode of the request held in item_r
  always_comb begin
    tgt_col  = item_r.use_cursor ? cur_col_r : item_r.col;
    tgt_row  = item_r.use_cursor ? cur_row_r : item_r.row;
    bad      = !item_r.use_cursor &&
               (({1'b0, item_r.col} >= (COL_W + 1)'(COLS)) ||
                ({1'b0, item_r.row} >= (ROW_W + 1)'(ROWS)));
    attr_sel = (item_r.attr == ATTR_NONE) ? def_attr_r : item_r.attr;

    addr_col      = tgt_col;
    addr_row      = tgt_row;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    scroll_needed = 1'b0;
    dec_we        = 1'b0;
    dec_waddr     = LAST_CELL;
    dec_wdata     = {err_attr_r, CH_ERR};

    case (item_r.mode)
      MODE_PUT: begin
        if (bad) begin
          dec_we = 1'b1;
        end else if (item_r.char_code == CH_NL) begin
          cur_col_nxt   = '0;
          scroll_needed = (tgt_row == LAST_ROW);
          cur_row_nxt   = scroll_needed ? LAST_ROW : tgt_row + ROW_W'(1);
        end else if (item_r.char_code == CH_CR) begin
          cur_col_nxt = '0;
          cur_row_nxt = tgt_row;
        end else if (item_r.char_code == CH_BLANK) begin
          dec_we      = 1'b1;
          dec_waddr   = cell_addr;
          dec_wdata   = {attr_sel, CH_SPACE};
          cur_col_nxt = tgt_col;
          cur_row_nxt = tgt_row;
        end else begin
          dec_we    = 1'b1;
          dec_waddr = cell_addr;
          dec_wdata = {attr_sel, item_r.char_code};
          if (tgt_col == LAST_COL) begin
            cur_col_nxt   = '0;
            scroll_needed = (tgt_row == LAST_ROW);
            cur_row_nxt   = scroll_needed ? LAST_ROW : tgt_row + ROW_W'(1);
          end else begin
            cur_col_nxt = tgt_col + COL_W'(1);
            cur_row_nxt = tgt_row;
          end
        end
      end
      MODE_BACK: begin
        // step back one cell, held at the home cell
        if (cur_col_r != '0) begin
          addr_col = cur_col_r - COL_W'(1);
          addr_row = cur_row_r;
        end else if (cur_row_r != '0) begin
          addr_col = LAST_COL;
          addr_row = cur_row_r - ROW_W'(1);
        end else begin
          addr_col = '0;
          addr_row = '0;
        end
        dec_we      = 1'b1;
        dec_waddr   = cell_addr;
        dec_wdata   = {def_attr_r, CH_SPACE};
        cur_col_nxt = addr_col;
        cur_row_nxt = addr_row;
      end
      MODE_CLEAR: begin
        cur_col_nxt = '0;
        cur_row_nxt = '0;
      end
      MODE_READ: begin
        cur_col_nxt = cur_col_r;
        cur_row_nxt = cur_row_r;
      end
      default: begin
        cur_col_nxt = cur_col_r;
        cur_row_nxt = cur_row_r;
      end
    endcase
  end

  assign cell_addr = ADDR_W'(addr_row) * ROW_STEP + ADDR_W'(addr_col);

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = {ATTR_NONE, CH_SPACE};
    if (cmd.exec) begin
      ram_we    = dec_we;
      ram_waddr = dec_waddr;
      ram_wdata = dec_wdata;
    end else if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.scr_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.fill_wr) begin
      ram_we    = 1'b1;
      ram_wdata = {ATTR_NONE, CH_NUL};
    end
    ram_raddr = cmd.scr_rd ? cnt_r + ROW_STEP : cell_addr;
  end

  tmtw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      def_attr_r  <= DEFAULT_ATTR_RST;
      err_attr_r  <= ERROR_ATTR_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEFAULT_ATTR: def_attr_r <= cfg_data;
          CFG_ERROR_ATTR:   err_attr_r <= cfg_data;
          default:          def_attr_r <= def_attr_r;
        endcase
      end
      if (cmd.exec) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
      end
      if (cmd.clr_wr || cmd.scr_wr || cmd.fill_wr) begin
        cnt_r <= (cnt_r == LAST_CELL) ? '0 : cnt_r + ADDR_W'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      err_r     <= bad && ((item_r.mode == MODE_PUT) || (item_r.mode == MODE_READ));
      rd_char_r <= '0;
      rd_attr_r <= '0;
    end else if (cmd.rd_cap && !err_r) begin
      rd_char_r <= ram_rdata[CHAR_W-1:0];
      rd_attr_r <= ram_rdata[CELL_W-1:CHAR_W];
    end
    if (cmd.finish) begin
      out_r.cursor_col  <= cur_col_r;
      out_r.cursor_row  <= cur_row_r;
      out_r.coord_error <= err_r;
      out_r.read_char   <= rd_char_r;
      out_r.read_attr   <= rd_attr_r;
    end
  end

  assign status.mode          = item_r.mode;
  assign status.scroll_needed = scroll_needed;
  assign status.cnt_last      = (cnt_r == LAST_CELL);
  assign status.cnt_copy_last = (cnt_r == LAST_COPY);
  assign status.out_free      = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ===== rtl/text_mode_terminal_writer.sv =====
// Character-cell text console writer, COLS x ROWS cells of char + attribute.
// Input channel (in_valid / in_stall / in_item): one request per item, put a
// character, backspace, clear the screen or read a cell. A request is taken
// only while the sequencer is idle; in_stall is high while one is in work.
// Result channel (out_valid / out_stall / out_item): exactly one result per
// request, carrying the cursor after the request, the coordinate error flag
// and, for reads, the addressed cell. The result sits in an output register,
// so the next request is taken while an earlier result still waits.
// From acceptance to result a put or backspace passes the decode and finish
// states; a read adds a registered screen memory read. A put that runs off
// the bottom row scrolls: each copied cell takes a read and a write step,
// then the cells of the bottom row are blanked. Clear writes one cell per
// cycle through the single memory write port.
// Reset (rst_n low, synchronous): cursor home, registers to their defaults,
// then a clearing pass blanks the screen before the first request is taken;
// configuration writes take effect at any time outside reset.
// A stalled result holds; the sequencer then waits before loading the next.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_terminal_writer
  import tmtw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_item,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ATTR_W-1:0]    cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // register file is always writable
  assign cfg_ready = 1'b1;

  // sequencer: reset clear, request decode, clear / scroll sweeps, result hand-off
  tmtw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // screen memory, cursor, configuration and result registers
  tmtw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
